FILE: rtl/core/plid_pkg.sv
package plid_pkg;

    localparam int MAX_LINE_UNITS_DEF = 128;
    localparam int DICT_ENTRIES_DEF   = 256;

    localparam logic [7:0] LINE_UNITS_RESET = 8'd80;
    localparam logic [7:0] RUN_BIAS         = 8'h12;
    localparam logic [4:0] CODE_WORD_BITS   = 5'd16;

    // run kinds 0..3: back reference at distance 1 << kind
    localparam logic [2:0] KIND_LAST = 3'd4;
    localparam logic [2:0] KIND_SKIP = 3'd5;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_in_cmd;

    typedef enum logic [2:0] {
        PH_CW_LO = 3'd0,
        PH_CW_HI = 3'd1,
        PH_CODE  = 3'd2,
        PH_NIB   = 3'd3,
        PH_OPER  = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        SYM_SKIP  = 3'd0,
        SYM_STORE = 3'd1,
        SYM_FETCH = 3'd2,
        SYM_MASK  = 3'd3,
        SYM_MOVE  = 3'd4,
        SYM_BACK  = 3'd5
    } t_sym;

    typedef enum logic [1:0] {
        MK_RESULT = 2'd0,
        MK_PUT    = 2'd1,
        MK_ACC    = 2'd2
    } t_mem_kind;

    typedef enum logic [1:0] {
        SRC_A    = 2'd0,
        SRC_B    = 2'd1,
        SRC_DICT = 2'd2
    } t_rd_src;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_LOAD   = 3'd1,
        OP_CODE   = 3'd2,
        OP_EXEC   = 3'd3,
        OP_MEM    = 3'd4,
        OP_RUN_RD = 3'd5,
        OP_RUN_WR = 3'd6,
        OP_END    = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        GO_FINISH = 3'd0,
        GO_CODE   = 3'd1,
        GO_EXEC   = 3'd2,
        GO_MEM    = 3'd3,
        GO_RUN    = 3'd4,
        GO_END    = 3'd5
    } t_go;

    typedef struct packed {
        t_op  op;
        logic out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        t_go nxt;
    } t_status;

    function automatic logic [31:0] plane_expand(input logic [3:0] nib);
        logic [31:0] u;
        u = '0;
        for (int p = 0; p < 4; p++) begin
            u[p*8 +: 8] = {8{nib[p]}};
        end
        return u;
    endfunction

endpackage

FILE: rtl/core/plid_ifs.sv
interface plid_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic [6:0] unit_index;

    modport source (output valid, output cmd, output data_byte, output unit_index, input ready);
    modport sink   (input valid, input cmd, input data_byte, input unit_index, output ready);
endinterface

interface plid_out_if;
    logic       valid;
    logic       ready;
    logic       line_done;
    logic [7:0] plane_zero;
    logic [7:0] plane_one;
    logic [7:0] plane_two;
    logic [7:0] plane_three;

    modport source (output valid, output line_done, output plane_zero, output plane_one,
                    output plane_two, output plane_three, input ready);
    modport sink   (input valid, input line_done, input plane_zero, input plane_one,
                    input plane_two, input plane_three, output ready);
endinterface

interface plid_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/planar_line_image_decoder.sv
// Planar line image decoder: takes one item per input handshake (start of chunk, one
// compressed stream byte, or a read of one unit of the last finished line) and returns
// exactly one result item per input item through a registered output, so a new item is
// taken while the previous result waits. Items are worked one at a time. A read goes
// through a registered line-store read, and every unit of a copy run is a registered
// line-store read followed by a write, so a long run holds input off. The line stores
// come out of reset zero through per-unit valid bits, so there is no clearing pass;
// the dictionary is undefined until stored into. Write line_units only while no item
// is in progress.
module planar_line_image_decoder #(
    parameter int MAX_LINE_UNITS = plid_pkg::MAX_LINE_UNITS_DEF,
    parameter int DICT_ENTRIES   = plid_pkg::DICT_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    plid_in_if.sink           i_in,
    plid_out_if.source        o_out,
    plid_cfg_if.sink          i_cfg
);
    import plid_pkg::*;

    t_ctrl_cmd ctrl_cmd;
    t_status   dp_status;
    logic      in_ready;
    logic      out_valid;

    // controller: handshake and sequencing of decode steps
    plid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_status    (dp_status),
        .o_cmd       (ctrl_cmd)
    );

    // datapath: code word, symbol context, line stores, dictionary, result register
    plid_dp #(
        .MAX_LINE_UNITS (MAX_LINE_UNITS),
        .DICT_ENTRIES   (DICT_ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (ctrl_cmd),
        .o_status      (dp_status),
        .i_in_cmd      (i_in.cmd),
        .i_data_byte   (i_in.data_byte),
        .i_unit_index  (i_in.unit_index),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_data    (i_cfg.data),
        .o_line_done   (o_out.line_done),
        .o_plane_zero  (o_out.plane_zero),
        .o_plane_one   (o_out.plane_one),
        .o_plane_two   (o_out.plane_two),
        .o_plane_three (o_out.plane_three)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    // configuration is always taken
    assign i_cfg.ready = 1'b1;
endmodule

FILE: rtl/core/plid_ram.sv
module plid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

FILE: rtl/core/plid_ctrl.sv
module plid_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  plid_pkg::t_status  i_status,
    output plid_pkg::t_ctrl_cmd o_cmd
);
    import plid_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CODE   = 8'b0000_0010,
        S_EXEC   = 8'b0000_0100,
        S_MEM    = 8'b0000_1000,
        S_RUN_RD = 8'b0001_0000,
        S_RUN_WR = 8'b0010_0000,
        S_END    = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    t_state route_state;
    logic   route_load;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        route_load  = 1'b0;
        route_state = S_IDLE;
        unique case (i_status.nxt)
            GO_FINISH: begin
                if (out_free) begin
                    route_load  = 1'b1;
                    route_state = S_IDLE;
                end else begin
                    route_state = S_OUT;
                end
            end
            GO_CODE: route_state = S_CODE;
            GO_EXEC: route_state = S_EXEC;
            GO_MEM:  route_state = S_MEM;
            GO_RUN:  route_state = S_RUN_RD;
            GO_END:  route_state = S_END;
            default: route_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = OP_NONE;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op       = OP_LOAD;
                    o_cmd.out_load = route_load;
                    n_state        = route_state;
                end
            end
            S_CODE: begin
                o_cmd.op       = OP_CODE;
                o_cmd.out_load = route_load;
                n_state        = route_state;
            end
            S_EXEC: begin
                o_cmd.op       = OP_EXEC;
                o_cmd.out_load = route_load;
                n_state        = route_state;
            end
            S_MEM: begin
                o_cmd.op       = OP_MEM;
                o_cmd.out_load = route_load;
                n_state        = route_state;
            end
            S_RUN_RD: begin
                o_cmd.op = OP_RUN_RD;
                n_state  = S_RUN_WR;
            end
            S_RUN_WR: begin
                o_cmd.op       = OP_RUN_WR;
                o_cmd.out_load = route_load;
                n_state        = route_state;
            end
            S_END: begin
                o_cmd.op       = OP_END;
                o_cmd.out_load = route_load;
                n_state        = route_state;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_out_valid = o_cmd.out_load || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

FILE: rtl/core/plid_dp.sv
module plid_dp #(
    parameter int MAX_LINE_UNITS = plid_pkg::MAX_LINE_UNITS_DEF,
    parameter int DICT_ENTRIES   = plid_pkg::DICT_ENTRIES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  plid_pkg::t_ctrl_cmd  i_cmd,
    output plid_pkg::t_status    o_status,
    input  logic [1:0]           i_in_cmd,
    input  logic [7:0]           i_data_byte,
    input  logic [6:0]           i_unit_index,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_data,
    output logic                 o_line_done,
    output logic [7:0]           o_plane_zero,
    output logic [7:0]           o_plane_one,
    output logic [7:0]           o_plane_two,
    output logic [7:0]           o_plane_three
);
    import plid_pkg::*;

    localparam int         AW   = $clog2(MAX_LINE_UNITS);
    localparam int         DAW  = $clog2(DICT_ENTRIES);
    localparam logic [8:0] MAX9 = 9'(MAX_LINE_UNITS);

    t_phase      r_phase, n_phase;
    logic [15:0] r_cw, n_cw;
    logic [4:0]  r_bits_left, n_bits_left;
    logic [3:0]  r_prefix, n_prefix;
    logic [2:0]  r_len, n_len;
    t_sym        r_sym, n_sym;
    logic [2:0]  r_step, n_step;
    logic [2:0]  r_plane, n_plane;
    logic [3:0]  r_mask, n_mask;
    logic [31:0] r_acc, n_acc;
    logic        r_pend_ok, n_pend_ok;
    logic [7:0]  r_pend, n_pend;
    logic [7:0]  r_held, n_held;
    logic        r_nib_held, n_nib_held;
    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_dict_pos, n_dict_pos;
    logic        r_cur_b, n_cur_b;
    logic [7:0]  r_line_units, n_line_units;
    logic        r_line_flag, n_line_flag;
    logic [31:0] r_unit, n_unit;
    t_mem_kind   r_mem_kind, n_mem_kind;
    t_rd_src     r_rd_src, n_rd_src;
    logic        r_rd_zero, n_rd_zero;
    logic [2:0]  r_run_kind, n_run_kind;
    logic [7:0]  r_run_cnt, n_run_cnt;
    logic        r_out_line_done;
    logic [31:0] r_out_unit;
    logic [MAX_LINE_UNITS-1:0] r_valid_a, r_valid_b;

    t_in_cmd     in_cmd;
    t_go         nxt;
    logic        nib_ok;
    logic [3:0]  nib_v;
    logic        res_ok;
    t_sym        res_sym;
    logic        put_en;
    logic [31:0] put_data;
    logic        run_go;
    logic [2:0]  run_kind_c;
    logic [7:0]  run_cnt_c;
    logic [8:0]  rd_addr9;
    logic [8:0]  dist9;
    logic        rd_valid;
    logic        line_wr_en;
    logic        dict_we;
    logic [DAW-1:0] dict_rd_addr;
    logic [31:0] a_rdata, b_rdata, dict_rdata, line_rdata, mem_unit;
    t_rd_src     cur_src, old_src;

    assign in_cmd  = t_in_cmd'(i_in_cmd);
    assign cur_src = r_cur_b ? SRC_B : SRC_A;
    assign old_src = r_cur_b ? SRC_A : SRC_B;
    assign nib_ok  = r_pend_ok || r_nib_held;
    assign nib_v   = r_pend_ok ? r_pend[3:0] : r_held[7:4];
    assign dist9   = 9'd1 << r_run_kind[1:0];

    assign line_rdata = (r_rd_src == SRC_B) ? b_rdata : a_rdata;
    assign mem_unit   = (r_rd_src == SRC_DICT) ? dict_rdata :
                        (r_rd_zero ? 32'd0 : line_rdata);

    always_comb begin
        res_ok  = 1'b0;
        res_sym = SYM_SKIP;
        if (r_len == 3'd2) begin
            unique case (r_prefix)
                4'd2:    begin res_ok = 1'b1; res_sym = SYM_SKIP; end
                4'd1:    begin res_ok = 1'b1; res_sym = SYM_MASK; end
                4'd0:    begin res_ok = 1'b1; res_sym = SYM_BACK; end
                default: res_ok = 1'b0;
            endcase
        end else if (r_len == 3'd3) begin
            res_ok  = (r_prefix == 4'd6);
            res_sym = SYM_STORE;
        end else if (r_len >= 3'd4) begin
            res_ok  = 1'b1;
            res_sym = r_prefix[0] ? SYM_FETCH : SYM_MOVE;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_cw         = r_cw;
        n_bits_left  = r_bits_left;
        n_prefix     = r_prefix;
        n_len        = r_len;
        n_sym        = r_sym;
        n_step       = r_step;
        n_plane      = r_plane;
        n_mask       = r_mask;
        n_acc        = r_acc;
        n_pend_ok    = r_pend_ok;
        n_pend       = r_pend;
        n_held       = r_held;
        n_nib_held   = r_nib_held;
        n_pos        = r_pos;
        n_dict_pos   = r_dict_pos;
        n_cur_b      = r_cur_b;
        n_line_units = i_cfg_we ? i_cfg_data : r_line_units;
        n_line_flag  = r_line_flag;
        n_unit       = r_unit;
        n_mem_kind   = r_mem_kind;
        n_rd_src     = r_rd_src;
        n_run_kind   = r_run_kind;
        n_run_cnt    = r_run_cnt;
        nxt          = GO_FINISH;
        put_en       = 1'b0;
        put_data     = r_acc;
        run_go       = 1'b0;
        run_kind_c   = KIND_SKIP;
        run_cnt_c    = 8'd0;
        rd_addr9     = {1'b0, r_pos};
        dict_we      = 1'b0;
        dict_rd_addr = r_pend[DAW-1:0];

        unique case (i_cmd.op)
            OP_LOAD: begin
                n_line_flag = 1'b0;
                n_unit      = '0;
                unique case (in_cmd)
                    CMD_START: begin
                        n_pos      = '0;
                        n_dict_pos = '0;
                        n_cw       = '0;
                        n_bits_left = '0;
                        n_held     = '0;
                        n_nib_held = 1'b0;
                        n_sym      = SYM_SKIP;
                        n_step     = '0;
                        n_plane    = '0;
                        n_mask     = '0;
                        n_acc      = '0;
                        n_prefix   = '0;
                        n_len      = '0;
                        n_pend_ok  = 1'b0;
                        n_pend     = '0;
                        n_phase    = PH_CW_LO;
                    end
                    CMD_BYTE: begin
                        unique case (r_phase)
                            PH_CW_LO: begin
                                n_cw    = {8'd0, i_data_byte};
                                n_phase = PH_CW_HI;
                            end
                            PH_CW_HI: begin
                                n_cw        = {i_data_byte, r_cw[7:0]};
                                n_bits_left = CODE_WORD_BITS;
                                n_phase     = PH_CODE;
                                nxt         = GO_CODE;
                            end
                            PH_NIB: begin
                                n_held     = i_data_byte;
                                n_nib_held = 1'b1;
                                n_pend     = {4'd0, i_data_byte[3:0]};
                                n_pend_ok  = 1'b1;
                                n_phase    = PH_CODE;
                                nxt        = GO_EXEC;
                            end
                            PH_OPER: begin
                                n_pend    = i_data_byte;
                                n_pend_ok = 1'b1;
                                n_phase   = PH_CODE;
                                nxt       = GO_EXEC;
                            end
                            default: nxt = GO_FINISH;
                        endcase
                    end
                    CMD_READ: begin
                        rd_addr9   = {2'd0, i_unit_index};
                        n_rd_src   = old_src;
                        n_mem_kind = MK_RESULT;
                        nxt        = GO_MEM;
                    end
                    default: nxt = GO_FINISH;
                endcase
            end

            OP_CODE: begin
                if (res_ok) begin
                    n_sym     = res_sym;
                    n_step    = '0;
                    n_plane   = '0;
                    n_mask    = '0;
                    n_acc     = '0;
                    n_prefix  = '0;
                    n_len     = '0;
                    n_pend_ok = 1'b0;
                    nxt       = GO_EXEC;
                end else if (r_bits_left == 5'd0) begin
                    n_phase = PH_CW_LO;
                end else begin
                    n_prefix    = {r_prefix[2:0], r_cw[15]};
                    n_len       = r_len + 3'd1;
                    n_cw        = {r_cw[14:0], 1'b0};
                    n_bits_left = r_bits_left - 5'd1;
                    if (r_bits_left == 5'd1) begin
                        n_phase = PH_CW_LO;
                    end else begin
                        nxt = GO_CODE;
                    end
                end
            end

            OP_EXEC: begin
                unique case (r_sym)
                    SYM_SKIP: begin
                        n_pos = r_pos + 8'd1;
                        nxt   = GO_END;
                    end
                    SYM_STORE: begin
                        if (!r_step[2]) begin
                            if (r_pend_ok) begin
                                n_acc[{r_step[1:0], 3'b000} +: 8] = r_pend;
                                n_pend_ok = 1'b0;
                                n_step    = r_step + 3'd1;
                                nxt       = GO_EXEC;
                            end else begin
                                n_phase = PH_OPER;
                            end
                        end else begin
                            dict_we    = 1'b1;
                            n_dict_pos = r_dict_pos + 8'd1;
                            put_en     = 1'b1;
                            put_data   = r_acc;
                            nxt        = GO_END;
                        end
                    end
                    SYM_FETCH: begin
                        if (r_pend_ok) begin
                            n_pend_ok  = 1'b0;
                            n_rd_src   = SRC_DICT;
                            n_mem_kind = MK_PUT;
                            nxt        = GO_MEM;
                        end else begin
                            n_phase = PH_OPER;
                        end
                    end
                    SYM_MASK, SYM_MOVE: begin
                        if (r_step == 3'd0) begin
                            if (nib_ok) begin
                                if (r_pend_ok) n_pend_ok = 1'b0;
                                else n_nib_held = 1'b0;
                                n_mask = nib_v;
                                if (r_sym == SYM_MASK && nib_v == 4'd15) begin
                                    n_rd_src   = old_src;
                                    n_mem_kind = MK_PUT;
                                    nxt        = GO_MEM;
                                end else if (nib_v == 4'd0 || nib_v == 4'd15) begin
                                    n_step = 3'd1;
                                    nxt    = GO_EXEC;
                                end else begin
                                    if (r_sym == SYM_MOVE) rd_addr9 = {1'b0, r_pos} - 9'd1;
                                    n_plane    = '0;
                                    n_step     = 3'd2;
                                    n_rd_src   = cur_src;
                                    n_mem_kind = MK_ACC;
                                    nxt        = GO_MEM;
                                end
                            end else begin
                                n_phase = PH_NIB;
                            end
                        end else if (r_step == 3'd1) begin
                            if (r_sym == SYM_MASK) begin
                                if (nib_ok) begin
                                    if (r_pend_ok) n_pend_ok = 1'b0;
                                    else n_nib_held = 1'b0;
                                    put_en   = 1'b1;
                                    put_data = plane_expand(nib_v);
                                    nxt      = GO_END;
                                end else begin
                                    n_phase = PH_NIB;
                                end
                            end else begin
                                if (r_pend_ok) begin
                                    n_pend_ok = 1'b0;
                                    run_go    = 1'b1;
                                    run_cnt_c = {2'd0, r_pend[5:0]} + RUN_BIAS;
                                    if (r_mask == 4'd0) run_kind_c = {1'b0, r_pend[7:6]};
                                    else if (r_pend[7:6] == 2'd0) run_kind_c = KIND_LAST;
                                    else run_kind_c = KIND_SKIP;
                                end else begin
                                    n_phase = PH_OPER;
                                end
                            end
                        end else begin
                            // plane fill over the base unit, one plane per cycle while operand bytes are at hand
                            if (r_plane[2]) begin
                                put_en   = 1'b1;
                                put_data = r_acc;
                                nxt      = GO_END;
                            end else if (r_mask[r_plane[1:0]]) begin
                                if (r_pend_ok) begin
                                    n_acc[{r_plane[1:0], 3'b000} +: 8] = r_pend;
                                    n_pend_ok = 1'b0;
                                    n_plane   = r_plane + 3'd1;
                                    nxt       = GO_EXEC;
                                end else begin
                                    n_phase = PH_OPER;
                                end
                            end else begin
                                n_plane = r_plane + 3'd1;
                                nxt     = GO_EXEC;
                            end
                        end
                    end
                    SYM_BACK: begin
                        if (nib_ok) begin
                            if (r_pend_ok) n_pend_ok = 1'b0;
                            else n_nib_held = 1'b0;
                            if (r_step == 3'd0) begin
                                n_mask = nib_v;
                                if (nib_v < 4'd4) begin
                                    run_go     = 1'b1;
                                    run_kind_c = {1'b0, nib_v[1:0]};
                                    run_cnt_c  = 8'd1;
                                end else if (nib_v >= 4'd10) begin
                                    run_go     = 1'b1;
                                    run_kind_c = 3'(nib_v - 4'd10);
                                    run_cnt_c  = r_line_units - r_pos;
                                end else begin
                                    n_step = 3'd1;
                                    nxt    = GO_EXEC;
                                end
                            end else begin
                                run_go     = 1'b1;
                                run_kind_c = 3'(r_mask - 4'd4);
                                run_cnt_c  = {4'd0, nib_v} + 8'd2;
                            end
                        end else begin
                            n_phase = PH_NIB;
                        end
                    end
                    default: nxt = GO_END;
                endcase
            end

            OP_MEM: begin
                unique case (r_mem_kind)
                    MK_RESULT: begin
                        n_unit = mem_unit;
                    end
                    MK_PUT: begin
                        put_en   = 1'b1;
                        put_data = mem_unit;
                        nxt      = GO_END;
                    end
                    MK_ACC: begin
                        n_acc = mem_unit;
                        nxt   = GO_EXEC;
                    end
                    default: nxt = GO_FINISH;
                endcase
            end

            OP_RUN_RD: begin
                if (r_run_kind == KIND_LAST) begin
                    n_rd_src = old_src;
                end else begin
                    rd_addr9 = {1'b0, r_pos} - dist9;
                    n_rd_src = cur_src;
                end
                nxt = GO_RUN;
            end

            OP_RUN_WR: begin
                put_en    = 1'b1;
                put_data  = mem_unit;
                n_run_cnt = r_run_cnt - 8'd1;
                nxt       = (r_run_cnt == 8'd1) ? GO_END : GO_RUN;
            end

            OP_END: begin
                if (r_pos >= r_line_units) begin
                    n_cur_b     = !r_cur_b;
                    n_pos       = '0;
                    n_line_flag = 1'b1;
                end
                n_phase = PH_CODE;
                nxt     = GO_CODE;
            end

            default: nxt = GO_FINISH;
        endcase

        if (run_go) begin
            if (run_kind_c >= KIND_SKIP) begin
                n_pos = r_pos + run_cnt_c;
                nxt   = GO_END;
            end else if (run_cnt_c == 8'd0) begin
                nxt = GO_END;
            end else begin
                n_run_kind = run_kind_c;
                n_run_cnt  = run_cnt_c;
                nxt        = GO_RUN;
            end
        end

        if (put_en) begin
            n_pos = r_pos + 8'd1;
        end
    end

    // reads before unit 0, past the store, or of a never-written entry give zero
    assign rd_valid  = (n_rd_src == SRC_B) ? r_valid_b[rd_addr9[AW-1:0]]
                                           : r_valid_a[rd_addr9[AW-1:0]];
    assign n_rd_zero = rd_addr9[8] || ({1'b0, rd_addr9[7:0]} >= MAX9) || !rd_valid;

    assign line_wr_en = put_en && ({1'b0, r_pos} < MAX9);
    assign o_status.nxt = nxt;

    plid_ram #(.WIDTH(32), .DEPTH(MAX_LINE_UNITS)) u_store_a (
        .i_clk     (i_clk),
        .i_wr_en   (line_wr_en && !r_cur_b),
        .i_wr_addr (r_pos[AW-1:0]),
        .i_wr_data (put_data),
        .i_rd_addr (rd_addr9[AW-1:0]),
        .o_rd_data (a_rdata)
    );

    plid_ram #(.WIDTH(32), .DEPTH(MAX_LINE_UNITS)) u_store_b (
        .i_clk     (i_clk),
        .i_wr_en   (line_wr_en && r_cur_b),
        .i_wr_addr (r_pos[AW-1:0]),
        .i_wr_data (put_data),
        .i_rd_addr (rd_addr9[AW-1:0]),
        .o_rd_data (b_rdata)
    );

    plid_ram #(.WIDTH(32), .DEPTH(DICT_ENTRIES)) u_dict (
        .i_clk     (i_clk),
        .i_wr_en   (dict_we),
        .i_wr_addr (r_dict_pos[DAW-1:0]),
        .i_wr_data (r_acc),
        .i_rd_addr (dict_rd_addr),
        .o_rd_data (dict_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_CW_LO;
            r_cw         <= '0;
            r_bits_left  <= '0;
            r_prefix     <= '0;
            r_len        <= '0;
            r_sym        <= SYM_SKIP;
            r_step       <= '0;
            r_plane      <= '0;
            r_mask       <= '0;
            r_pend_ok    <= 1'b0;
            r_pend       <= '0;
            r_held       <= '0;
            r_nib_held   <= 1'b0;
            r_pos        <= '0;
            r_dict_pos   <= '0;
            r_cur_b      <= 1'b0;
            r_line_units <= LINE_UNITS_RESET;
            r_line_flag  <= 1'b0;
            r_mem_kind   <= MK_RESULT;
            r_rd_src     <= SRC_A;
            r_rd_zero    <= 1'b1;
            r_run_kind   <= KIND_SKIP;
            r_run_cnt    <= '0;
            r_valid_a    <= '0;
            r_valid_b    <= '0;
        end else begin
            r_phase      <= n_phase;
            r_cw         <= n_cw;
            r_bits_left  <= n_bits_left;
            r_prefix     <= n_prefix;
            r_len        <= n_len;
            r_sym        <= n_sym;
            r_step       <= n_step;
            r_plane      <= n_plane;
            r_mask       <= n_mask;
            r_pend_ok    <= n_pend_ok;
            r_pend       <= n_pend;
            r_held       <= n_held;
            r_nib_held   <= n_nib_held;
            r_pos        <= n_pos;
            r_dict_pos   <= n_dict_pos;
            r_cur_b      <= n_cur_b;
            r_line_units <= n_line_units;
            r_line_flag  <= n_line_flag;
            r_mem_kind   <= n_mem_kind;
            r_rd_src     <= n_rd_src;
            r_rd_zero    <= n_rd_zero;
            r_run_kind   <= n_run_kind;
            r_run_cnt    <= n_run_cnt;
            if (line_wr_en && !r_cur_b) r_valid_a[r_pos[AW-1:0]] <= 1'b1;
            if (line_wr_en && r_cur_b)  r_valid_b[r_pos[AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_unit <= n_unit;
        if (i_cmd.out_load) begin
            r_out_line_done <= n_line_flag;
            r_out_unit      <= n_unit;
        end
    end

    assign o_line_done   = r_out_line_done;
    assign o_plane_zero  = r_out_unit[7:0];
    assign o_plane_one   = r_out_unit[15:8];
    assign o_plane_two   = r_out_unit[23:16];
    assign o_plane_three = r_out_unit[31:24];
endmodule

FILE: rtl/core/plid_checker.sv
module plid_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_cmd,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_line_done,
    input logic [7:0] i_plane_zero,
    input logic [7:0] i_plane_one,
    input logic [7:0] i_plane_two,
    input logic [7:0] i_plane_three
);
    import plid_pkg::*;

    logic       in_acc, out_acc;
    logic [1:0] r_pending;
    logic [1:0] r_last_cmd;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= '0;
            r_last_cmd <= CMD_NONE;
        end else begin
            r_pending <= r_pending + {1'b0, in_acc} - {1'b0, out_acc};
            if (in_acc) r_last_cmd <= i_in_cmd;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_line_done) && $stable(i_plane_zero)
            && $stable(i_plane_one) && $stable(i_plane_two) && $stable(i_plane_three))
        else $error("stalled result changed");

    a_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 2'd2 && !(out_acc && r_pending == 2'd0))
        else $error("results out of step with items");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_pending == 2'd1 && (r_last_cmd == CMD_START || r_last_cmd == CMD_NONE)
        |-> !i_line_done && i_plane_zero == 8'd0 && i_plane_one == 8'd0
            && i_plane_two == 8'd0 && i_plane_three == 8'd0)
        else $error("start or unused command gave a nonzero result");
endmodule

bind planar_line_image_decoder plid_checker u_plid_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_cmd      (i_in.cmd),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_line_done   (o_out.line_done),
    .i_plane_zero  (o_out.plane_zero),
    .i_plane_one   (o_out.plane_one),
    .i_plane_two   (o_out.plane_two),
    .i_plane_three (o_out.plane_three)
);

FILE: tb/plid_line_checker.sv
`timescale 1ns / 1ps

// Watches the three channels, keeps its own copy of the decoder state and
// compares every result item with the oldest predicted one.
module plid_line_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    plid_in_if   in_mon,
    plid_out_if  out_mon,
    plid_cfg_if  cfg_mon,
    output int   o_errors,
    output int   o_pending,
    output int   o_lines
);
    import plid_pkg::*;

    typedef enum logic [2:0] {
        WAIT_WORD_LO, WAIT_WORD_HI, DECODE_PREFIX, RUN_SYMBOL, WAIT_NIBBLE, WAIT_OPERAND
    } t_dec_state;

    typedef struct packed {
        logic        line_done;
        logic [31:0] unit;
    } t_line_result;

    logic [31:0] store_a [MAX_LINE_UNITS_DEF];
    logic [31:0] store_b [MAX_LINE_UNITS_DEF];
    logic [31:0] dict [DICT_ENTRIES_DEF];
    logic        write_to_b;
    logic [7:0]  units;
    logic [7:0]  dict_ptr;
    logic [7:0]  pos;
    logic [15:0] word;
    int          word_bits;
    logic [7:0]  nib_byte;
    logic        nib_ok;
    t_dec_state  st;
    t_sym        sym;
    int          sym_step;
    int          plane;
    logic [3:0]  mask;
    logic [31:0] acc;
    logic [3:0]  prefix;
    int          plen;
    logic        have_op;
    logic [7:0]  op_val;
    logic        finished;

    t_line_result expected_q[$];

    // prev selects the last finished line, otherwise the line being built
    function automatic logic [31:0] line_rd(bit prev, int idx);
        if (idx < 0 || idx >= MAX_LINE_UNITS_DEF) return '0;
        return (prev ^ write_to_b) ? store_b[idx] : store_a[idx];
    endfunction

    function automatic void put_unit(logic [31:0] u);
        if (pos < MAX_LINE_UNITS_DEF) begin
            if (write_to_b) store_b[pos] = u;
            else store_a[pos] = u;
        end
        pos = pos + 8'd1;
    endfunction

    function automatic void copy_run(int kind, int count);
        if (kind >= KIND_SKIP) begin
            pos = pos + 8'(count);
            return;
        end
        for (int k = 0; k < count; k++) begin
            if (kind == KIND_LAST) put_unit(line_rd(1, int'(pos)));
            else put_unit(line_rd(0, int'(pos) - (1 << kind)));
        end
    endfunction

    function automatic int take_operand();
        if (have_op) begin
            have_op = 0;
            return int'(op_val);
        end
        st = WAIT_OPERAND;
        return -1;
    endfunction

    // low nibble of a fresh byte first, its high nibble on the next request
    function automatic int take_nibble();
        if (have_op) begin
            have_op = 0;
            return int'(op_val);
        end
        if (nib_ok) begin
            nib_ok = 0;
            return int'(nib_byte[7:4]);
        end
        st = WAIT_NIBBLE;
        return -1;
    endfunction

    function automatic bit load_planes();
        int v;
        while (plane < 4) begin
            if (mask[plane]) begin
                v = take_operand();
                if (v < 0) return 0;
                acc[plane*8 +: 8] = v[7:0];
            end
            plane++;
        end
        put_unit(acc);
        return 1;
    endfunction

    function automatic bit run_symbol();
        int v;
        int n;
        logic [31:0] u;
        case (sym)
            SYM_SKIP: begin
                pos = pos + 8'd1;
                return 1;
            end
            SYM_STORE: begin
                while (sym_step < 4) begin
                    v = take_operand();
                    if (v < 0) return 0;
                    acc[sym_step*8 +: 8] = acc[sym_step*8 +: 8] | v[7:0];
                    sym_step++;
                end
                dict[dict_ptr] = acc;
                dict_ptr = dict_ptr + 8'd1;
                put_unit(acc);
                return 1;
            end
            SYM_FETCH: begin
                v = take_operand();
                if (v < 0) return 0;
                put_unit(dict[v[7:0]]);
                return 1;
            end
            SYM_MASK: begin
                if (sym_step == 0) begin
                    v = take_nibble();
                    if (v < 0) return 0;
                    mask = v[3:0];
                    if (v == 15) begin
                        put_unit(line_rd(1, int'(pos)));
                        return 1;
                    end
                    if (v == 0) sym_step = 1;
                    else begin
                        acc = line_rd(0, int'(pos));
                        plane = 0;
                        sym_step = 2;
                    end
                end
                if (sym_step == 1) begin
                    v = take_nibble();
                    if (v < 0) return 0;
                    u = '0;
                    for (int p = 0; p < 4; p++) if (v[p]) u[p*8 +: 8] = 8'hFF;
                    put_unit(u);
                    return 1;
                end
                return load_planes();
            end
            SYM_MOVE: begin
                if (sym_step == 0) begin
                    v = take_nibble();
                    if (v < 0) return 0;
                    mask = v[3:0];
                    if (v == 0 || v == 15) sym_step = 1;
                    else begin
                        acc = line_rd(0, int'(pos) - 1);
                        plane = 0;
                        sym_step = 2;
                    end
                end
                if (sym_step == 1) begin
                    v = take_operand();
                    if (v < 0) return 0;
                    n = (v & 'h3F) + int'(RUN_BIAS);
                    if (mask == 4'd0) copy_run(v >> 6, n);
                    else if ((v & 'hC0) == 0) copy_run(KIND_LAST, n);
                    else copy_run(KIND_SKIP, n);
                    return 1;
                end
                return load_planes();
            end
            default: begin
                if (sym_step == 0) begin
                    v = take_nibble();
                    if (v < 0) return 0;
                    mask = v[3:0];
                    if (v < 4) begin
                        copy_run(v, 1);
                        return 1;
                    end
                    if (v >= 10) begin
                        // run to end of line
                        copy_run(v - 10, (int'(units) + 256 - int'(pos)) & 255);
                        return 1;
                    end
                    sym_step = 1;
                end
                v = take_nibble();
                if (v < 0) return 0;
                copy_run(int'(mask) - 4, v + 2);
                return 1;
            end
        endcase
    endfunction

    function automatic int sym_of_prefix();
        if (plen == 2) begin
            if (prefix == 4'd2) return int'(SYM_SKIP);
            if (prefix == 4'd1) return int'(SYM_MASK);
            if (prefix == 4'd0) return int'(SYM_BACK);
        end else if (plen == 3) begin
            if (prefix == 4'd6) return int'(SYM_STORE);
        end else if (plen >= 4) begin
            return prefix[0] ? int'(SYM_FETCH) : int'(SYM_MOVE);
        end
        return -1;
    endfunction

    task automatic decode_more();
        int s;
        forever begin
            if (st == DECODE_PREFIX) begin
                s = sym_of_prefix();
                if (s < 0) begin
                    if (word_bits == 0) begin
                        st = WAIT_WORD_LO;
                        return;
                    end
                    prefix = {prefix[2:0], word[15]};
                    plen++;
                    word = word << 1;
                    word_bits--;
                    // word refills as soon as its last bit is gone
                    if (word_bits == 0) begin
                        st = WAIT_WORD_LO;
                        return;
                    end
                    continue;
                end
                sym = t_sym'(s);
                sym_step = 0;
                plane = 0;
                mask = '0;
                acc = '0;
                prefix = '0;
                plen = 0;
                have_op = 0;
                st = RUN_SYMBOL;
            end
            if (st != RUN_SYMBOL) return;
            if (!run_symbol()) return;
            if (pos >= units) begin
                write_to_b = !write_to_b;
                pos = '0;
                finished = 1;
            end
            st = DECODE_PREFIX;
        end
    endtask

    function automatic void chunk_start();
        pos = '0;
        dict_ptr = '0;
        word = '0;
        word_bits = 0;
        nib_byte = '0;
        nib_ok = 0;
        sym = SYM_SKIP;
        sym_step = 0;
        plane = 0;
        mask = '0;
        acc = '0;
        prefix = '0;
        plen = 0;
        have_op = 0;
        op_val = '0;
        st = WAIT_WORD_LO;
    endfunction

    task automatic predict(input t_in_cmd c, input logic [7:0] b, input logic [6:0] ix,
                           output t_line_result r);
        logic [31:0] u;
        u = '0;
        finished = 0;
        case (c)
            CMD_START: chunk_start();
            CMD_BYTE: begin
                case (st)
                    WAIT_WORD_LO: begin
                        word = {8'h00, b};
                        st = WAIT_WORD_HI;
                    end
                    WAIT_WORD_HI: begin
                        word[15:8] = b;
                        word_bits = int'(CODE_WORD_BITS);
                        st = DECODE_PREFIX;
                        decode_more();
                    end
                    WAIT_NIBBLE: begin
                        nib_byte = b;
                        nib_ok = 1;
                        op_val = {4'h0, b[3:0]};
                        have_op = 1;
                        st = RUN_SYMBOL;
                        decode_more();
                    end
                    WAIT_OPERAND: begin
                        op_val = b;
                        have_op = 1;
                        st = RUN_SYMBOL;
                        decode_more();
                    end
                    default: ;
                endcase
            end
            CMD_READ: u = line_rd(1, int'(ix));
            default: ;
        endcase
        r.line_done = finished;
        r.unit = u;
    endtask

    always @(posedge i_clk) begin
        t_line_result got;
        t_line_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_LINE_UNITS_DEF; i++) begin
                store_a[i] = '0;
                store_b[i] = '0;
            end
            for (int i = 0; i < DICT_ENTRIES_DEF; i++) dict[i] = '0;
            write_to_b = 0;
            units = LINE_UNITS_RESET;
            finished = 0;
            chunk_start();
            expected_q.delete();
            o_errors = 0;
            o_lines = 0;
        end else begin
            if (cfg_mon.valid && cfg_mon.ready) units = cfg_mon.data;
            if (out_mon.valid && out_mon.ready) begin
                got.line_done = out_mon.line_done;
                got.unit = {out_mon.plane_three, out_mon.plane_two,
                            out_mon.plane_one, out_mon.plane_zero};
                if (expected_q.size() == 0) begin
                    $error("result item with nothing expected");
                    o_errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.line_done) o_lines++;
                    if (got.line_done !== want.line_done) begin
                        $error("line_done: expected %0d, got %0d", want.line_done, got.line_done);
                        o_errors++;
                    end
                    if (got.unit[7:0] !== want.unit[7:0]) begin
                        $error("plane_zero: expected %0h, got %0h", want.unit[7:0], got.unit[7:0]);
                        o_errors++;
                    end
                    if (got.unit[15:8] !== want.unit[15:8]) begin
                        $error("plane_one: expected %0h, got %0h",
                               want.unit[15:8], got.unit[15:8]);
                        o_errors++;
                    end
                    if (got.unit[23:16] !== want.unit[23:16]) begin
                        $error("plane_two: expected %0h, got %0h",
                               want.unit[23:16], got.unit[23:16]);
                        o_errors++;
                    end
                    if (got.unit[31:24] !== want.unit[31:24]) begin
                        $error("plane_three: expected %0h, got %0h",
                               want.unit[31:24], got.unit[31:24]);
                        o_errors++;
                    end
                end
            end
            if (in_mon.valid && in_mon.ready) begin
                predict(t_in_cmd'(in_mon.cmd), in_mon.data_byte, in_mon.unit_index, want);
                expected_q.insert(expected_q.size(), want);
            end
        end
        o_pending = expected_q.size();
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

// Stimulus for the planar line decoder. Streams are built symbol by symbol
// and then laid out in the byte order the decoder consumes them: code words
// reload eagerly (even mid-symbol), nibbles share a byte low-then-high.
// Checking lives in plid_line_checker; this module only drives and judges.
module testbench;
    import plid_pkg::*;

    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int SETTLE_CYCLES = 600;
    localparam int PHASE_ITEMS = 310;

    typedef enum logic [1:0] { TK_BIT, TK_BYTE, TK_NIB, TK_STORED } t_tok_kind;
    typedef struct packed {
        t_tok_kind  kind;
        logic [7:0] val;
    } t_token;

    logic i_clk;
    logic i_rst_n;

    plid_in_if  in_ch();
    plid_out_if out_ch();
    plid_cfg_if cfg_ch();

    int errors, pending, lines_seen;
    int cycles;
    int items_sent, reads_sent, cfg_writes;
    bit in_idle, out_idle;
    int hold_cycles;

    // stream under construction
    t_token     tok_q[$];
    bit         code_q[$];
    logic [7:0] chunk_bytes[$];
    int         code_ptr;
    int         chunk_stores;   // stores in the current chunk so far
    int         dict_filled;    // dictionary entries 0..dict_filled-1 hold data

    planar_line_image_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    plid_line_checker line_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_mon    (in_ch),
        .out_mon   (out_ch),
        .cfg_mon   (cfg_ch),
        .o_errors  (errors),
        .o_pending (pending),
        .o_lines   (lines_seen)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // result side: random stalls, plus a long hold-off when asked
    initial begin
        int g;
        out_ch.ready = 0;
        hold_cycles = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                out_ch.ready <= 0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end else if (out_idle) begin
                g = $urandom_range(0, 16);
                if (g > 0) begin
                    out_ch.ready <= 0;
                    repeat (g) @(posedge i_clk);
                end
            end
            out_ch.ready <= 1;
            do @(negedge i_clk); while (!out_ch.valid);
            @(posedge i_clk);
        end
    end

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic send_item(input t_in_cmd c, input logic [7:0] b, input logic [6:0] ix);
        int g;
        g = in_idle ? $urandom_range(0, 16) : 0;
        if (g > 0) begin
            in_ch.valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        in_ch.cmd        <= c;
        in_ch.data_byte  <= b;
        in_ch.unit_index <= ix;
        in_ch.valid      <= 1;
        do @(negedge i_clk); while (!in_ch.ready);
        @(posedge i_clk);
        items_sent++;
        if (c == CMD_READ) reads_sent++;
    endtask

    // sender waits for every result, then for the block to go quiet
    task automatic drain();
        in_ch.valid <= 0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_units(input logic [7:0] v);
        cfg_ch.data  <= v;
        cfg_ch.valid <= 1;
        do @(negedge i_clk); while (!cfg_ch.ready);
        @(posedge i_clk);
        cfg_ch.valid <= 0;
        cfg_writes++;
    endtask

    function automatic void add_tok(t_tok_kind k, logic [7:0] v);
        t_token t;
        t.kind = k;
        t.val = v;
        tok_q.insert(tok_q.size(), t);
    endfunction

    function automatic void add_code(int bits, int n);
        for (int i = n - 1; i >= 0; i--) add_tok(TK_BIT, {7'd0, bits[i]});
    endfunction

    function automatic int pick_mask();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0) return 0;
        if (r == 1) return 15;
        return $urandom_range(0, 15);
    endfunction

    // one symbol with its operands; sel forces the first nibble when >= 0
    function automatic void add_sym(t_sym s, int sel = -1);
        int m;
        int avail;
        case (s)
            SYM_SKIP: add_code('b10, 2);
            SYM_STORE: begin
                add_code('b110, 3);
                repeat (4) add_tok(TK_BYTE, 8'($urandom));
                add_tok(TK_STORED, 8'd0);
                chunk_stores++;
            end
            SYM_FETCH: begin
                avail = (chunk_stores > dict_filled) ? chunk_stores : dict_filled;
                if (avail > DICT_ENTRIES_DEF) avail = DICT_ENTRIES_DEF;
                add_code('b1111, 4);
                add_tok(TK_BYTE, 8'($urandom_range(0, avail - 1)));
            end
            SYM_MASK: begin
                add_code('b01, 2);
                m = (sel < 0) ? pick_mask() : sel;
                add_tok(TK_NIB, 8'(m));
                if (m == 0) add_tok(TK_NIB, 8'($urandom_range(0, 15)));
                else if (m != 15)
                    for (int p = 0; p < 4; p++) if (m[p]) add_tok(TK_BYTE, 8'($urandom));
            end
            SYM_MOVE: begin
                add_code('b1110, 4);
                m = (sel < 0) ? pick_mask() : sel;
                add_tok(TK_NIB, 8'(m));
                if (m == 0 || m == 15) add_tok(TK_BYTE, 8'($urandom));
                else for (int p = 0; p < 4; p++) if (m[p]) add_tok(TK_BYTE, 8'($urandom));
            end
            default: begin
                add_code('b00, 2);
                m = (sel < 0) ? $urandom_range(0, 15) : sel;
                add_tok(TK_NIB, 8'(m));
                if (m >= 4 && m <= 9) add_tok(TK_NIB, 8'($urandom_range(0, 15)));
            end
        endcase
    endfunction

    function automatic void add_random_sym();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) add_sym(SYM_SKIP);
        else if (r < 30) add_sym(SYM_STORE);
        else if (r < 45) begin
            if (chunk_stores == 0 && dict_filled == 0) add_sym(SYM_STORE);
            else add_sym(SYM_FETCH);
        end
        else if (r < 65) add_sym(SYM_MASK);
        else if (r < 78) add_sym(SYM_MOVE);
        else add_sym(SYM_BACK);
    endfunction

    function automatic void push_word();
        logic [15:0] w;
        w = '0;
        for (int i = 0; i < 16; i++)
            if (code_ptr + i < code_q.size()) w[15-i] = code_q[code_ptr+i];
        code_ptr += 16;
        chunk_bytes.insert(chunk_bytes.size(), w[7:0]);
        chunk_bytes.insert(chunk_bytes.size(), w[15:8]);
    endfunction

    // Lay the tokens out in consumption order and send them after a chunk
    // start. A broken chunk is cut off at a random byte.
    task automatic send_chunk(input bit broken);
        int left, slot, cut, done_stores;
        int store_ends[$];
        code_q.delete();
        chunk_bytes.delete();
        code_ptr = 0;
        foreach (tok_q[i])
            if (tok_q[i].kind == TK_BIT) code_q.insert(code_q.size(), tok_q[i].val[0]);
        push_word();
        left = 16;
        slot = -1;
        foreach (tok_q[i]) begin
            case (tok_q[i].kind)
                TK_BIT: begin
                    left--;
                    if (left == 0) begin
                        push_word();
                        left = 16;
                    end
                end
                TK_BYTE: chunk_bytes.insert(chunk_bytes.size(), tok_q[i].val);
                TK_NIB: begin
                    if (slot >= 0) begin
                        chunk_bytes[slot][7:4] = tok_q[i].val[3:0];
                        slot = -1;
                    end else begin
                        chunk_bytes.insert(chunk_bytes.size(),
                                           {4'($urandom), tok_q[i].val[3:0]});
                        slot = chunk_bytes.size() - 1;
                    end
                end
                default: store_ends.insert(store_ends.size(), chunk_bytes.size());
            endcase
        end
        cut = broken ? $urandom_range(0, chunk_bytes.size()) : chunk_bytes.size();
        send_item(CMD_START, 8'($urandom), 7'($urandom));
        for (int i = 0; i < cut; i++) send_item(CMD_BYTE, chunk_bytes[i], 7'($urandom));
        // only stores whose last byte went out reached the dictionary
        done_stores = 0;
        foreach (store_ends[i]) if (store_ends[i] <= cut) done_stores++;
        if (done_stores > DICT_ENTRIES_DEF) done_stores = DICT_ENTRIES_DEF;
        if (done_stores > dict_filled) dict_filled = done_stores;
        tok_q.delete();
        chunk_stores = 0;
    endtask

    task automatic random_chunk(input bit broken);
        repeat ($urandom_range(1, 12)) add_random_sym();
        send_chunk(broken);
    endtask

    task automatic random_traffic(input int stop_at);
        int r;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 7) == 0) in_idle = !in_idle;
            if ($urandom_range(0, 7) == 0) out_idle = !out_idle;
            r = $urandom_range(0, 9);
            if (r < 7) random_chunk(0);
            else if (r == 7) repeat ($urandom_range(1, 4))
                send_item(CMD_READ, 8'($urandom), 7'($urandom));
            else if (r == 8) begin
                // unused command, then a lone chunk start
                send_item(CMD_NONE, 8'($urandom), 7'($urandom));
                send_item(CMD_START, 8'($urandom), 7'($urandom));
            end
            else random_chunk(1);
        end
    endtask

    initial begin
        logic [7:0] unit_settings[6];
        unit_settings = '{8'd1, 8'd128, 8'd3, 8'd16, 8'd45, 8'd80};
        in_ch.valid = 0;
        in_ch.cmd = CMD_NONE;
        in_ch.data_byte = '0;
        in_ch.unit_index = '0;
        cfg_ch.valid = 0;
        cfg_ch.data = '0;
        items_sent = 0;
        reads_sent = 0;
        cfg_writes = 0;
        chunk_stores = 0;
        dict_filled = 0;
        in_idle = 1;
        out_idle = 1;
        i_rst_n = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: reads of the untouched stores at both ends, the unused
        // command, then one chunk with every symbol and its special forms at
        // the reset line length (literal, fetch, skip, copy from previous line,
        // all-zero and all-one plane masks, a partial mask, a back run, a skip or
        // previous-line run, a single back reference, run to end of line, counted back run).
        send_item(CMD_READ, 8'h00, 7'd0);
        send_item(CMD_READ, 8'hFF, 7'd127);
        send_item(CMD_NONE, 8'hFF, 7'd127);
        add_sym(SYM_STORE);
        add_sym(SYM_FETCH);
        add_sym(SYM_SKIP);
        add_sym(SYM_MASK, 15);
        add_sym(SYM_MASK, 0);
        add_sym(SYM_MASK, 5);
        add_sym(SYM_MOVE, 0);
        add_sym(SYM_MOVE, 15);
        add_sym(SYM_BACK, 2);
        add_sym(SYM_BACK, 12);
        add_sym(SYM_BACK, 7);
        send_chunk(0);
        send_item(CMD_READ, 8'h00, 7'd0);

        foreach (unit_settings[k]) begin
            drain();
            write_units(unit_settings[k]);
            if (k == 1) begin
                // result side holds off while the sender keeps offering items
                in_idle = 0;
                hold_cycles = 400;
                random_chunk(0);
            end
            random_traffic(items_sent + PHASE_ITEMS);
        end

        drain();
        $display("Covered %0d items (%0d reads) over %0d line length settings, %0d lines done",
                 items_sent, reads_sent, cfg_writes, lines_seen);
        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/plid_pkg.sv
rtl/core/plid_ifs.sv
rtl/core/plid_ram.sv
rtl/core/plid_ctrl.sv
rtl/core/plid_dp.sv
rtl/core/planar_line_image_decoder.sv
rtl/core/plid_checker.sv
tb/plid_line_checker.sv
tb/testbench.sv
